### sv/maf_pkg.sv
// Shared constants, register codes and types of the moving-average tap filter.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package maf_pkg;

	// Sizing of the delay line and the sample path
	localparam int MAX_TAPS     = 64;
	localparam int SAMPLE_BITS  = 16;
	localparam int LENGTHNOTSET = 0;

	localparam int CNT_W     = $clog2(MAX_TAPS);
	localparam int LEN_W     = 7;
	localparam int TAP_W     = 8;
	localparam int SCALE_W   = 16;
	localparam int FRAC_BITS = 8;
	localparam int MEAN_W    = SAMPLE_BITS + FRAC_BITS;
	localparam int PROD_W    = MEAN_W + SCALE_W;
	localparam int SCALED_W  = PROD_W - 1;
	localparam int DIFF_W    = SAMPLE_BITS + 1;
	localparam int SUM_W     = SAMPLE_BITS + CNT_W;
	localparam int DVD_W     = SUM_W + FRAC_BITS;

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_READOUT_TAP   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_LAG     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_SCALE    = CFG_IDX_W'(3);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	// Per-cycle command broadcast to every delay-line cell
	typedef struct packed {
		logic clear;
		logic shift;
		logic rotate;
	} cell_ctl_t;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [LEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

### sv/maf_if.sv
// Valid/ready channel interfaces for samples, results and configuration writes.
// Depends on maf_pkg for field widths.
`default_nettype none

interface maf_in_if;
	logic             valid;
	logic             ready;
	maf_pkg::sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface maf_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [maf_pkg::MEAN_W-1:0]   mean;
	logic signed [maf_pkg::SCALED_W-1:0] scaled_mean;
	logic signed [maf_pkg::SAMPLE_BITS-1:0] tap_value;
	logic                                tap_ok;
	logic signed [maf_pkg::DIFF_W-1:0]   difference;
	logic                                difference_ok;
	logic                                active;

	modport source (output valid, output mean, output scaled_mean, output tap_value,
		output tap_ok, output difference, output difference_ok, output active,
		input ready);
	modport sink   (input valid, input mean, input scaled_mean, input tap_value,
		input tap_ok, input difference, input difference_ok, input active,
		output ready);
endinterface

interface maf_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [maf_pkg::CFG_IDX_W-1:0]      index;
	logic [maf_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/maf_cell.sv
// One delay-line cell: holds a sample, shifts from the newer-side neighbor or
// rotates from the older-side neighbor. Depends on maf_pkg.
`default_nettype none

module maf_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  maf_pkg::cell_ctl_t ctl,
	input  maf_pkg::sample_t   prev_data,
	input  maf_pkg::sample_t   next_data,
	output maf_pkg::sample_t   data
);
	import maf_pkg::*;

	sample_t data_q;

	// Clear, shift in a new sample, or rotate the ring by one place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctl.clear) begin
			data_q <= '0;
		end else if (ctl.shift) begin
			data_q <= prev_data;
		end else if (ctl.rotate) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

### sv/maf_div.sv
// Restoring divider, one quotient bit per cycle, for the window mean.
// Depends on maf_pkg for the dividend and divisor widths.
`default_nettype none

module maf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  maf_pkg::div_req_t req,
	output maf_pkg::div_rsp_t rsp
);
	import maf_pkg::*;

	localparam int STEP_W = $clog2(DVD_W);

	logic [DVD_W-1:0]  dvd_q;
	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W-1:0]  dsr_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [LEN_W:0]    trial;
	logic              fits;

	// Trial subtract of the divisor from the partial remainder
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		fits  = trial >= {1'b0, dsr_q};
	end

	// Step count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the dividend out and the quotient bits in
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? LEN_W'(trial - {1'b0, dsr_q}) : trial[LEN_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

`default_nettype wire

### sv/moving_average_tap_filter_core.sv
// Moving-average tap filter: each sample beat is shifted into a delay line of
// MAX_TAPS cells (64) and yields one result beat with the window mean (8
// fraction bits, truncated toward zero), the mean times mean_scale, one chosen
// tap and the newest sample minus a lagged tap. For each item the cell ring is
// rotated once through all cells to pick out the leaving sample and the two
// taps, then the sum is updated as the sample is shifted in, the restoring
// divider works out the mean one quotient bit per cycle, the product is
// formed and the result beat is loaded. A result that still waits on the
// output register at that point holds the item until it is taken. The next
// sample is taken only after the result beat is loaded. With window_length 0
// the sequencer goes straight to loading the all-zero result once the output
// register is free.
// The block takes the next sample while a result still waits on the output
// register. A window_length write clears the delay line at once; the
// configuration port is always ready. Depends on maf_pkg, maf_if, maf_cell
// and maf_div.
`default_nettype none

module moving_average_tap_filter_core (
	input logic        clk,
	input logic        arst_n,
	maf_in_if.sink     samples,
	maf_out_if.source  results,
	maf_cfg_if.sink    cfg
);
	import maf_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROT  = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	// Configuration registers
	logic [LEN_W-1:0]          wlen_q;
	logic [TAP_W-1:0]          rtap_q;
	logic [TAP_W-1:0]          lag_q;
	logic signed [SCALE_W-1:0] scale_q;

	// Control
	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             zero_q;
	logic             out_valid_q;

	// Item datapath
	sample_t                  sample_q;
	sample_t                  leave_q;
	sample_t                  tapv_q;
	sample_t                  lagv_q;
	logic                     neg_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic signed [PROD_W-1:0] prod_q;

	// Output register
	logic signed [MEAN_W-1:0]      mean_o;
	logic signed [SCALED_W-1:0]    scaled_o;
	logic signed [SAMPLE_BITS-1:0] tap_o;
	logic                          tap_ok_o;
	logic signed [DIFF_W-1:0]      diff_o;
	logic                          diff_ok_o;
	logic                          active_o;

	logic                    in_take;
	logic                    clear_store;
	logic [LEN_W-1:0]        eff_len;
	logic                    hit_leave;
	logic                    hit_tap;
	logic                    hit_lag;
	logic signed [SUM_W-1:0] sum_nxt;
	logic [SUM_W-1:0]        sum_mag;
	logic                    out_free;
	logic                    tap_in;
	logic                    lag_in;
	sample_t                 tap_src;
	sample_t                 lag_src;
	logic                    sat;
	cell_ctl_t               cell_ctl;
	div_req_t                div_req;
	div_rsp_t                div_rsp;
	sample_t                 cell_data [MAX_TAPS];

	assign samples.ready = (state_q == ST_IDLE);
	assign in_take       = samples.valid && samples.ready;
	assign cfg.ready     = 1'b1;
	assign clear_store   = cfg.valid && (cfg.index == REG_WINDOW_LENGTH);

	// Clamp the window length to the delay-line depth
	always_comb begin
		eff_len = (int'(wlen_q) > MAX_TAPS) ? LEN_W'(MAX_TAPS) : wlen_q;
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q  <= LEN_W'(LENGTHNOTSET);
			rtap_q  <= TAP_W'(1);
			lag_q   <= TAP_W'(1);
			scale_q <= SCALE_W'(1);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WINDOW_LENGTH: wlen_q  <= cfg.data[LEN_W-1:0];
				REG_READOUT_TAP:   rtap_q  <= cfg.data[TAP_W-1:0];
				REG_DERIV_LAG:     lag_q   <= cfg.data[TAP_W-1:0];
				REG_MEAN_SCALE:    scale_q <= signed'(cfg.data[SCALE_W-1:0]);
				default: ;
			endcase
		end
	end

	// Delay-line ring: cell 0 holds the newest sample
	assign cell_ctl.clear  = clear_store;
	assign cell_ctl.shift  = (state_q == ST_SUM);
	assign cell_ctl.rotate = (state_q == ST_ROT);

	for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
		sample_t prev_d;
		sample_t next_d;
		if (i == 0) begin : g_head
			assign prev_d = sample_q;
		end else begin : g_body
			assign prev_d = cell_data[i-1];
		end
		if (i == MAX_TAPS - 1) begin : g_wrap
			assign next_d = cell_data[0];
		end else begin : g_link
			assign next_d = cell_data[i+1];
		end
		maf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.prev_data (prev_d),
			.next_data (next_d),
			.data      (cell_data[i])
		);
	end

	// Old tap k passes cell 0 at rotation count k; new tap k is old tap k-1
	always_comb begin
		hit_leave = int'(cnt_q) == int'(eff_len) - 1;
		hit_tap   = int'(cnt_q) == int'(rtap_q) - 1;
		hit_lag   = int'(cnt_q) == int'(lag_q) - 1;
	end

	// Running sum and divider operand
	always_comb begin
		sum_nxt = sum_q - SUM_W'(leave_q) + SUM_W'(sample_q);
		sum_mag = sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : SUM_W'(sum_nxt);
	end

	assign div_req.start    = (state_q == ST_SUM);
	assign div_req.dividend = {sum_mag, {FRAC_BITS{1'b0}}};
	assign div_req.divisor  = eff_len;

	maf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			zero_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						cnt_q <= '0;
						if (eff_len == LEN_W'(LENGTHNOTSET)) begin
							zero_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							zero_q  <= 1'b0;
							state_q <= ST_ROT;
						end
					end
				end
				ST_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MAX_TAPS - 1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Window sum, cleared with the delay line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (clear_store) begin
			sum_q <= '0;
		end else if (state_q == ST_SUM) begin
			sum_q <= sum_nxt;
		end
	end

	// Capture operands as the ring turns, then mean and product
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= samples.sample;
		end
		if (state_q == ST_ROT) begin
			if (hit_leave) leave_q <= cell_data[0];
			if (hit_tap)   tapv_q  <= cell_data[0];
			if (hit_lag)   lagv_q  <= cell_data[0];
		end
		if (state_q == ST_SUM) begin
			neg_q <= sum_nxt[SUM_W-1];
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			mean_q <= neg_q ? -signed'(div_rsp.quotient[MEAN_W-1:0])
			                : signed'(div_rsp.quotient[MEAN_W-1:0]);
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(scale_q) * PROD_W'(mean_q);
		end
	end

	// Result fields
	always_comb begin
		out_free = !out_valid_q || results.ready;
		tap_in   = int'(rtap_q) < int'(eff_len);
		lag_in   = int'(lag_q) < int'(eff_len);
		tap_src  = (rtap_q == '0) ? sample_q : tapv_q;
		lag_src  = (lag_q == '0) ? sample_q : lagv_q;
		sat      = !prod_q[PROD_W-1] && prod_q[PROD_W-2];
	end

	// Output register: hold until taken, load when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			if (zero_q) begin
				mean_o    <= '0;
				scaled_o  <= '0;
				tap_o     <= '0;
				tap_ok_o  <= 1'b0;
				diff_o    <= '0;
				diff_ok_o <= 1'b0;
				active_o  <= 1'b0;
			end else begin
				mean_o    <= mean_q;
				scaled_o  <= sat ? {1'b0, {(SCALED_W-1){1'b1}}} : prod_q[SCALED_W-1:0];
				tap_o     <= tap_in ? tap_src : '0;
				tap_ok_o  <= tap_in;
				diff_o    <= lag_in ? (DIFF_W'(sample_q) - DIFF_W'(lag_src)) : '0;
				diff_ok_o <= lag_in;
				active_o  <= 1'b1;
			end
		end
	end

	assign results.valid         = out_valid_q;
	assign results.mean          = mean_o;
	assign results.scaled_mean   = scaled_o;
	assign results.tap_value     = tap_o;
	assign results.tap_ok        = tap_ok_o;
	assign results.difference    = diff_o;
	assign results.difference_ok = diff_ok_o;
	assign results.active        = active_o;

endmodule

`default_nettype wire

### sv/maf_checker.sv
// Port-level checks on the moving-average tap filter, bound to the top level.
// Depends on maf_pkg for field widths and on moving_average_tap_filter_core.
`default_nettype none

module maf_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [maf_pkg::MEAN_W-1:0]      mean,
	input logic signed [maf_pkg::SCALED_W-1:0]    scaled_mean,
	input logic signed [maf_pkg::SAMPLE_BITS-1:0] tap_value,
	input logic                                   tap_ok,
	input logic signed [maf_pkg::DIFF_W-1:0]      difference,
	input logic                                   difference_ok,
	input logic                                   active
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean) && $stable(scaled_mean)
			&& $stable(tap_value) && $stable(difference))
		else $error("result beat changed while stalled");

	// One item in flight: intake closes after a sample beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while an item was at work");

	// An idle result carries zeros everywhere
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> mean == '0 && scaled_mean == '0 && tap_value == '0
			&& !tap_ok && difference == '0 && !difference_ok)
		else $error("nonzero field in an idle result");

	// Out-of-window tap and lag read as zero
	a_window_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tap_ok || tap_value == '0) && (difference_ok || difference == '0))
		else $error("out-of-window tap or lag is not zero");

endmodule

bind moving_average_tap_filter_core maf_checker u_maf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (samples.valid),
	.in_ready      (samples.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.mean          (results.mean),
	.scaled_mean   (results.scaled_mean),
	.tap_value     (results.tap_value),
	.tap_ok        (results.tap_ok),
	.difference    (results.difference),
	.difference_ok (results.difference_ok),
	.active        (results.active)
);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for moving_average_tap_filter_core: a plan-fed driver sends sample
// and register write beats, a monitor predicts each result beat and checks it field by field.
// Depends on maf_pkg and the channel interfaces of maf_if.

module testbench;
	import maf_pkg::*;

	localparam int WATCH_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 150;
	localparam int RANDOM_ITEMS  = 1250;
	localparam int HIGH_W        = CFG_DATA_W - TAP_W;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

	localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

	typedef enum logic [1:0] {STEP_SAMPLE, STEP_WRITE, STEP_DRAIN, STEP_MOOD} step_kind_t;

	typedef struct {
		step_kind_t            kind;
		sample_t               sample;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} plan_step_t;

	typedef struct {
		logic signed [MEAN_W-1:0]   mean;
		logic signed [SCALED_W-1:0] scaled_mean;
		sample_t                    tap_value;
		logic                       tap_ok;
		logic signed [DIFF_W-1:0]   difference;
		logic                       difference_ok;
		logic                       active;
	} avg_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	maf_in_if  samples_ch();
	maf_out_if results_ch();
	maf_cfg_if cfg_ch();

	// Bench-side copies of everything driven into the block, known from time zero
	logic                  in_valid  = 1'b0;
	sample_t               in_sample = '0;
	logic                  out_ready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	assign samples_ch.valid  = in_valid;
	assign samples_ch.sample = in_sample;
	assign results_ch.ready  = out_ready;
	assign cfg_ch.valid      = cfg_valid;
	assign cfg_ch.index      = cfg_index;
	assign cfg_ch.data       = cfg_data;

	moving_average_tap_filter_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	// Filter state as seen from the outside
	logic [LEN_W-1:0]          win_len  = LEN_W'(LENGTHNOTSET);
	logic [TAP_W-1:0]          pick_tap = TAP_W'(1);
	logic [TAP_W-1:0]          lag_tap  = TAP_W'(1);
	logic signed [SCALE_W-1:0] scale    = SCALE_W'(1);
	sample_t                   taps [MAX_TAPS] = '{default: '0};
	longint                    win_sum  = 0;
	int unsigned               wr_ptr   = 0;

	plan_step_t  sample_plan [$];
	avg_result_t averages_due [$];
	avg_result_t want;

	int   fault_count   = 0;
	int   idle_cycles   = 0;
	int   gap_left      = 0;
	int   stall_left    = 0;
	int   quiet         = 0;
	logic calm          = 1'b0;
	logic in_beat_done  = 1'b0;
	logic cfg_beat_done = 1'b0;
	logic nxt_in_valid;
	logic nxt_cfg_valid;
	logic nxt_calm;

	// Slot of tap k once the newest sample is in
	function automatic int unsigned slot_of(int unsigned k);
		return (wr_ptr + 2 * MAX_TAPS - 1 - k) % MAX_TAPS;
	endfunction

	function automatic void apply_write(logic [CFG_IDX_W-1:0] index,
		logic [CFG_DATA_W-1:0] data);
		case (index)
			REG_WINDOW_LENGTH: begin
				// Any length write empties the window, same value or not
				win_len = data[LEN_W-1:0];
				foreach (taps[i])
					taps[i] = '0;
				win_sum = 0;
				wr_ptr  = 0;
			end
			REG_READOUT_TAP: pick_tap = data[TAP_W-1:0];
			REG_DERIV_LAG:   lag_tap  = data[TAP_W-1:0];
			REG_MEAN_SCALE:  scale    = data;
			default: ;
		endcase
	endfunction

	// Shift one sample into the window and work out the result beat it yields
	function automatic avg_result_t avg_take_sample(sample_t s);
		avg_result_t r;
		int unsigned len;
		int unsigned leaving;
		longint m;
		longint p;
		longint d;
		r = '{default: '0};
		len = (win_len > MAX_TAPS) ? MAX_TAPS : win_len;
		if (len == LENGTHNOTSET)
			return r;
		leaving = (wr_ptr + MAX_TAPS - len) % MAX_TAPS;
		win_sum = win_sum - taps[leaving] + s;
		taps[wr_ptr] = s;
		wr_ptr = (wr_ptr + 1) % MAX_TAPS;
		m = (win_sum * 256) / longint'(len);
		p = longint'(scale) * m;
		// Only the most negative scale times the most negative mean lands here
		if (p > (longint'(1) <<< (SCALED_W - 1)) - 1)
			p = (longint'(1) <<< (SCALED_W - 1)) - 1;
		r.mean        = m[MEAN_W-1:0];
		r.scaled_mean = p[SCALED_W-1:0];
		if (pick_tap < len) begin
			r.tap_value = taps[slot_of(pick_tap)];
			r.tap_ok    = 1'b1;
		end
		if (lag_tap < len) begin
			d = longint'(taps[slot_of(0)]) - longint'(taps[slot_of(lag_tap)]);
			r.difference    = d[DIFF_W-1:0];
			r.difference_ok = 1'b1;
		end
		r.active = 1'b1;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 16);
		return $urandom_range(20, 150);
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			3: return sample_t'(-1);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic void plan_sample(sample_t s);
		sample_plan.push_back('{STEP_SAMPLE, s, '0, '0});
	endfunction

	function automatic void plan_write(logic [CFG_IDX_W-1:0] index,
		logic [CFG_DATA_W-1:0] data);
		sample_plan.push_back('{STEP_WRITE, '0, index, data});
	endfunction

	function automatic void plan_drain();
		sample_plan.push_back('{STEP_DRAIN, '0, '0, '0});
	endfunction

	function automatic void plan_mood(logic quiet_run);
		sample_plan.push_back('{STEP_MOOD, '0, '0, CFG_DATA_W'(quiet_run)});
	endfunction

	initial begin
		forever #4 clk = ~clk;
	end

	// Drive one beat at a time from the plan; register writes only once the block is idle
	always @(negedge clk) begin
		if (arst_n) begin
			nxt_in_valid  = in_valid && !in_beat_done;
			nxt_cfg_valid = cfg_valid && !cfg_beat_done;
			nxt_calm      = calm;
			if (averages_due.size() == 0 && !nxt_in_valid)
				quiet = quiet + 1;
			else
				quiet = 0;
			if (!nxt_in_valid && !nxt_cfg_valid && sample_plan.size() != 0) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
				end else begin
					case (sample_plan[0].kind)
						STEP_SAMPLE: begin
							in_sample    <= sample_plan[0].sample;
							nxt_in_valid  = 1'b1;
							void'(sample_plan.pop_front());
							gap_left = calm ? 0 : draw_gap();
						end
						STEP_WRITE: begin
							if (quiet >= SETTLE_CYCLES) begin
								cfg_index     <= sample_plan[0].index;
								cfg_data      <= sample_plan[0].data;
								nxt_cfg_valid  = 1'b1;
								void'(sample_plan.pop_front());
							end
						end
						STEP_DRAIN: begin
							// Hold the sender until every result is back
							if (averages_due.size() == 0)
								void'(sample_plan.pop_front());
						end
						default: begin
							nxt_calm = sample_plan[0].data[0];
							void'(sample_plan.pop_front());
						end
					endcase
				end
			end
			in_valid  <= nxt_in_valid;
			cfg_valid <= nxt_cfg_valid;
			calm      <= nxt_calm;
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 12) begin
			stall_left = draw_gap();
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Track accepted beats, predict on each sample, check each result
	always @(posedge clk) begin
		if (arst_n) begin
			in_beat_done  <= samples_ch.valid && samples_ch.ready;
			cfg_beat_done <= cfg_ch.valid && cfg_ch.ready;
			if (cfg_ch.valid && cfg_ch.ready)
				apply_write(cfg_ch.index, cfg_ch.data);
			if (samples_ch.valid && samples_ch.ready)
				averages_due.push_back(avg_take_sample(samples_ch.sample));
			if (results_ch.valid && results_ch.ready) begin
				if (averages_due.size() == 0) begin
					$error("result beat with no sample pending");
					fault_count++;
				end else begin
					want = averages_due.pop_front();
					if (results_ch.mean !== want.mean) begin
						$error("mean: expected %0d, actual %0d", want.mean, results_ch.mean);
						fault_count++;
					end
					if (results_ch.scaled_mean !== want.scaled_mean) begin
						$error("scaled_mean: expected %0d, actual %0d",
							want.scaled_mean, results_ch.scaled_mean);
						fault_count++;
					end
					if (results_ch.tap_value !== want.tap_value) begin
						$error("tap_value: expected %0d, actual %0d",
							want.tap_value, results_ch.tap_value);
						fault_count++;
					end
					if (results_ch.tap_ok !== want.tap_ok) begin
						$error("tap_ok: expected %0d, actual %0d", want.tap_ok, results_ch.tap_ok);
						fault_count++;
					end
					if (results_ch.difference !== want.difference) begin
						$error("difference: expected %0d, actual %0d",
							want.difference, results_ch.difference);
						fault_count++;
					end
					if (results_ch.difference_ok !== want.difference_ok) begin
						$error("difference_ok: expected %0d, actual %0d",
							want.difference_ok, results_ch.difference_ok);
						fault_count++;
					end
					if (results_ch.active !== want.active) begin
						$error("active: expected %0d, actual %0d", want.active, results_ch.active);
						fault_count++;
					end
				end
			end
		end
	end

	// Watchdog: give up after a long stretch with no beat on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles == WATCH_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int total;
		int run;
		int len;
		int lim;
		logic flat;
		sample_t hold;
		logic [CFG_DATA_W-1:0] data;

		// Length not set: samples are ignored and the result is all zero
		plan_sample(S_MIN);
		plan_sample(S_MAX);

		// One-tap window with tap zero and lag zero; the saturating product comes first
		plan_write(REG_WINDOW_LENGTH, CFG_DATA_W'(1));
		plan_write(REG_READOUT_TAP, CFG_DATA_W'(0));
		plan_write(REG_DERIV_LAG, CFG_DATA_W'(0));
		plan_write(REG_MEAN_SCALE, 16'h8000);
		plan_sample(S_MIN);
		plan_sample(S_MAX);
		plan_sample('0);

		// Two taps, largest positive scale
		plan_write(REG_WINDOW_LENGTH, CFG_DATA_W'(2));
		plan_write(REG_READOUT_TAP, CFG_DATA_W'(1));
		plan_write(REG_DERIV_LAG, CFG_DATA_W'(1));
		plan_write(REG_MEAN_SCALE, 16'h7FFF);
		plan_sample(S_MAX);
		plan_sample(S_MAX);
		plan_sample(S_MIN);
		plan_sample(sample_t'(-1));

		// Length past the delay line, junk in the upper data bits, tap and lag off the window
		plan_drain();
		plan_write(REG_WINDOW_LENGTH, 16'hAB7F);
		plan_write(REG_READOUT_TAP, 16'h00FF);
		plan_write(REG_DERIV_LAG, 16'h5540);
		plan_write(REG_MEAN_SCALE, 16'hFFFF);
		plan_sample(S_MIN);
		plan_sample(S_MAX);
		plan_sample(S_MIN);
		plan_sample(pick_sample());
		plan_sample(pick_sample());

		// Writes to unknown indexes change nothing
		plan_write(REG_UNUSED_FIRST, 16'hFFFF);
		plan_write(REG_UNUSED_LAST, 16'h0000);
		plan_sample(pick_sample());

		// Rewriting the same length still empties the window
		plan_write(REG_WINDOW_LENGTH, CFG_DATA_W'(3));
		plan_write(REG_READOUT_TAP, CFG_DATA_W'(2));
		plan_write(REG_DERIV_LAG, CFG_DATA_W'(2));
		plan_sample(S_MAX);
		plan_sample(pick_sample());
		plan_sample(pick_sample());
		plan_write(REG_WINDOW_LENGTH, CFG_DATA_W'(3));
		plan_sample(S_MIN);

		// Back to length not set
		plan_write(REG_WINDOW_LENGTH, CFG_DATA_W'(LENGTHNOTSET));
		plan_sample(S_MAX);

		// Random phases: new settings, then a run of samples
		total = 0;
		len = 0;
		while (total < RANDOM_ITEMS) begin
			plan_mood($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 2) == 0)
				plan_drain();
			if ($urandom_range(0, 4) != 0) begin
				case ($urandom_range(0, 9))
					0: len = 0;
					1: len = 1;
					2: len = 2;
					3: len = MAX_TAPS;
					4: len = $urandom_range(MAX_TAPS + 1, (1 << LEN_W) - 1);
					9: len = $urandom_range(9, MAX_TAPS);
					default: len = $urandom_range(1, 8);
				endcase
				data = CFG_DATA_W'(len);
				if ($urandom_range(0, 3) == 0)
					data = data | (CFG_DATA_W'($urandom_range(0, 511)) << LEN_W);
				plan_write(REG_WINDOW_LENGTH, data);
			end
			lim = (len == 0) ? 0 : ((len > MAX_TAPS) ? MAX_TAPS : len) - 1;
			data = ($urandom_range(0, 9) < 7) ? CFG_DATA_W'($urandom_range(0, lim))
				: CFG_DATA_W'($urandom_range(0, (1 << TAP_W) - 1));
			if ($urandom_range(0, 3) == 0)
				data[CFG_DATA_W-1:TAP_W] = HIGH_W'($urandom);
			plan_write(REG_READOUT_TAP, data);
			data = ($urandom_range(0, 9) < 7) ? CFG_DATA_W'($urandom_range(0, lim))
				: CFG_DATA_W'($urandom_range(0, (1 << TAP_W) - 1));
			if ($urandom_range(0, 3) == 0)
				data[CFG_DATA_W-1:TAP_W] = HIGH_W'($urandom);
			plan_write(REG_DERIV_LAG, data);
			case ($urandom_range(0, 7))
				0: data = 16'h8000;
				1: data = 16'h7FFF;
				2: data = 16'h0000;
				3: data = 16'h0001;
				4: data = 16'hFFFF;
				default: data = CFG_DATA_W'($urandom);
			endcase
			plan_write(REG_MEAN_SCALE, data);
			if ($urandom_range(0, 9) == 0)
				plan_write(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
					CFG_DATA_W'($urandom));

			// Long windows get runs that wrap the delay line now and then
			run = $urandom_range(5, 40);
			if (len > 8 && $urandom_range(0, 1) == 0)
				run = ((len > MAX_TAPS) ? MAX_TAPS : len) + $urandom_range(0, 20);
			flat = ($urandom_range(0, 5) == 0);
			hold = $urandom_range(0, 1) ? S_MIN : S_MAX;
			repeat (run)
				plan_sample(flat ? hold : pick_sample());
			total = total + run;
		end

		// Single reset at the start of the run
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (sample_plan.size() != 0 || in_valid || cfg_valid || averages_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
